[rtl/rpel_pkg.sv]
// Package for the remote PIN entry lock: constants, codes, result type, key lookup.
`default_nettype none
package rpel_pkg;

  localparam int PIN_DIGITS = 4;
  localparam int BUF_DIGITS = 4;
  localparam int ENTRY_LEN  = (PIN_DIGITS < 1) ? 1 :
                              ((PIN_DIGITS > BUF_DIGITS) ? BUF_DIGITS : PIN_DIGITS);

  localparam int CODE_W  = 8;
  localparam int MS_W    = 16;
  localparam int PIN_W   = 16;
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 3;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] ENTRY_LEN_C = COUNT_W'(ENTRY_LEN);

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_KEY   = 2'd1;
  localparam logic [OP_W-1:0] OP_GRANT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OK       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISARM   = 3'd5;

  localparam logic [MS_W-1:0]   RST_COOLDOWN = 16'd300;
  localparam logic [MS_W-1:0]   RST_IDLE_TO  = 16'd3000;
  localparam logic [PIN_W-1:0]  RST_PIN      = 16'h1234;
  localparam logic [CODE_W-1:0] RST_OK       = 8'h1C;
  localparam logic [CODE_W-1:0] RST_CLEAR    = 8'h16;
  localparam logic [CODE_W-1:0] RST_DISARM   = 8'h0D;
  localparam logic [CODE_W-1:0] RST_PREV     = 8'hFF;
  localparam logic [MS_W-1:0]   MS_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [PIN_W-1:0]   entered_pin;
    logic [COUNT_W-1:0] digit_count;
    logic               disarm_pressed;
    logic               clear_pressed;
    logic               pin_correct;
    logic               pin_ready;
    logic               accepted;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  typedef struct packed {
    logic               hit;
    logic [DIGIT_W-1:0] digit;
  } digit_hit_t;

  function automatic digit_hit_t key_to_digit(input logic [CODE_W-1:0] code);
    digit_hit_t r;
    r.hit = 1'b1;
    unique case (code)
      8'h19:   r.digit = 4'd0;
      8'h45:   r.digit = 4'd1;
      8'h46:   r.digit = 4'd2;
      8'h47:   r.digit = 4'd3;
      8'h44:   r.digit = 4'd4;
      8'h40:   r.digit = 4'd5;
      8'h43:   r.digit = 4'd6;
      8'h07:   r.digit = 4'd7;
      8'h15:   r.digit = 4'd8;
      8'h09:   r.digit = 4'd9;
      default: begin
        r.hit   = 1'b0;
        r.digit = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/rpel_core.sv]
// Config registers, entry state and the combinational step logic for each input beat.
`default_nettype none
module rpel_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [rpel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rpel_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                step,
  input  wire logic [rpel_pkg::OP_W-1:0]           opcode,
  input  wire logic [rpel_pkg::CODE_W-1:0]         key_code,
  output rpel_pkg::result_t                        result
);

  logic [rpel_pkg::MS_W-1:0]   cooldown_ms;
  logic [rpel_pkg::MS_W-1:0]   idle_timeout_ms;
  logic [rpel_pkg::PIN_W-1:0]  stored_pin;
  logic [rpel_pkg::CODE_W-1:0] ok_code;
  logic [rpel_pkg::CODE_W-1:0] clear_code;
  logic [rpel_pkg::CODE_W-1:0] disarm_code;

  logic [rpel_pkg::BUF_DIGITS-1:0][rpel_pkg::DIGIT_W-1:0] digits, digits_next;
  logic [rpel_pkg::COUNT_W-1:0] count, count_next;
  logic [rpel_pkg::CODE_W-1:0]  prev_code, prev_code_next;
  logic [rpel_pkg::MS_W-1:0]    idle_ms, idle_ms_next;

  logic [rpel_pkg::MS_W-1:0] idle_inc;
  logic                      pin_equal;
  rpel_pkg::digit_hit_t      dh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_ms     <= rpel_pkg::RST_COOLDOWN;
      idle_timeout_ms <= rpel_pkg::RST_IDLE_TO;
      stored_pin      <= rpel_pkg::RST_PIN;
      ok_code         <= rpel_pkg::RST_OK;
      clear_code      <= rpel_pkg::RST_CLEAR;
      disarm_code     <= rpel_pkg::RST_DISARM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpel_pkg::REG_COOLDOWN: cooldown_ms     <= cfg_data;
        rpel_pkg::REG_IDLE_TO:  idle_timeout_ms <= cfg_data;
        rpel_pkg::REG_PIN:      stored_pin      <= cfg_data;
        rpel_pkg::REG_OK:       ok_code         <= cfg_data[rpel_pkg::CODE_W-1:0];
        rpel_pkg::REG_CLEAR:    clear_code      <= cfg_data[rpel_pkg::CODE_W-1:0];
        rpel_pkg::REG_DISARM:   disarm_code     <= cfg_data[rpel_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pin_equal = 1'b1;
    for (int i = 0; i < rpel_pkg::BUF_DIGITS; i++) begin
      if (i < rpel_pkg::ENTRY_LEN &&
          digits[i] != stored_pin[i*rpel_pkg::DIGIT_W +: rpel_pkg::DIGIT_W]) begin
        pin_equal = 1'b0;
      end
    end
  end

  assign idle_inc = (idle_ms != rpel_pkg::MS_MAX) ? idle_ms + 1'b1 : idle_ms;
  assign dh       = rpel_pkg::key_to_digit(key_code);

  always_comb begin
    digits_next    = digits;
    count_next     = count;
    prev_code_next = prev_code;
    idle_ms_next   = idle_ms;
    result         = '0;
    unique case (opcode)
      rpel_pkg::OP_TICK: begin
        idle_ms_next = idle_inc;
        if (idle_inc > idle_timeout_ms && count != '0) begin
          count_next           = '0;
          result.clear_pressed = 1'b1;
        end
      end
      rpel_pkg::OP_KEY: begin
        if (!(key_code == prev_code && idle_ms < cooldown_ms)) begin
          result.accepted = 1'b1;
          prev_code_next  = key_code;
          idle_ms_next    = '0;
          priority if (key_code == clear_code && count != '0) begin
            count_next           = '0;
            result.clear_pressed = 1'b1;
          end else if (key_code == ok_code) begin
            result.pin_ready = 1'b1;
            if (count == rpel_pkg::ENTRY_LEN_C) begin
              result.pin_correct = pin_equal;
              count_next         = '0;
            end
          end else if (key_code == disarm_code) begin
            result.disarm_pressed = 1'b1;
          end else if (dh.hit && count < rpel_pkg::ENTRY_LEN_C) begin
            digits_next[count[1:0]] = dh.digit;
            count_next              = count + 1'b1;
          end
        end
      end
      rpel_pkg::OP_GRANT: count_next = '0;
      default: ;
    endcase
    result.digit_count = count_next;
    result.entered_pin = digits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits    <= '0;
      count     <= '0;
      prev_code <= rpel_pkg::RST_PREV;
      idle_ms   <= '0;
    end else if (step) begin
      digits    <= digits_next;
      count     <= count_next;
      prev_code <= prev_code_next;
      idle_ms   <= idle_ms_next;
    end
  end

endmodule
`default_nettype wire

[rtl/rpel_skid.sv]
// Two-entry output buffer: result register plus skid register, registered ready.
`default_nettype none
module rpel_skid (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire rpel_pkg::result_t            push_data,
  output logic                              can_push,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [rpel_pkg::RESULT_W-1:0]     m_tdata
);

  rpel_pkg::result_t out_data, skid_data;
  logic              out_valid, skid_valid;
  logic              pop;

  assign pop      = out_valid && m_tready;
  assign can_push = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/remote_pin_entry_lock_top.sv]
// Top level of the remote PIN entry lock.
// Input stream: one beat per event. s_tuser selects the event: millisecond tick,
// received remote key code (s_tdata), or empty the entry after access granted.
// Output stream: exactly one result beat per input beat, in order, carrying the
// flags of that event and the entry buffer state after it.
// The result of each input beat is registered in the output buffer, which drives m_tvalid.
// Throughput: one beat per cycle while s_tready is high; the step logic (key decode,
// repeat check, PIN compare) sits between the state registers and the result register.
// Stall: results queue in a two-deep output buffer; s_tready drops only when
// both entries are full and rises again as soon as one is taken.
// Reset (rst, synchronous): config registers return to their defaults, the
// entry is emptied, the last key code is 0xFF, the idle counter is zero and
// the output buffer is empty.
// Config writes (cfg_we, cfg_index, cfg_data) take effect the next cycle and
// are expected only while no result is outstanding.
`default_nettype none
module remote_pin_entry_lock_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [rpel_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rpel_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [rpel_pkg::CODE_W-1:0]        s_tdata,  // [7:0] key_code
  input  wire logic [rpel_pkg::OP_W-1:0]          s_tuser,  // [1:0] opcode
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [0] accepted, [1] pin_ready, [2] pin_correct, [3] clear_pressed,
  // [4] disarm_pressed, [7:5] digit_count, [23:8] entered_pin
  output logic [rpel_pkg::RESULT_W-1:0]           m_tdata
);

  logic              beat;
  rpel_pkg::result_t result;

  assign beat = s_tvalid && s_tready;

  rpel_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (beat),
    .opcode    (s_tuser),
    .key_code  (s_tdata),
    .result    (result)
  );

  rpel_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (beat),
    .push_data (result),
    .can_push  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire
